@@ rtl/verilog_subset_lexer_unit_macros.svh @@
// assertion macros for the lexer unit
// used by the rtl files that carry checks; expects clk and rst_n in scope
`ifndef VERILOG_SUBSET_LEXER_UNIT_MACROS_SVH
`define VERILOG_SUBSET_LEXER_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define VSL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lexer check failed");

// next-cycle implication, checked out of reset
`define VSL_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lexer check failed");

`endif

@@ rtl/vsl_pkg.sv @@
// shared types, character codes, keyword table and token class logic
// no dependencies; used by the controller, datapath and top level
package vsl_pkg;

  // token classes
  localparam logic [3:0] CLS_DECL      = 4'd0;
  localparam logic [3:0] CLS_MODULE    = 4'd1;
  localparam logic [3:0] CLS_ENDMODULE = 4'd2;
  localparam logic [3:0] CLS_BRACKET   = 4'd3;
  localparam logic [3:0] CLS_COMMA     = 4'd4;
  localparam logic [3:0] CLS_SEMI      = 4'd5;
  localparam logic [3:0] CLS_NUMBER    = 4'd6;
  localparam logic [3:0] CLS_ASSIGN_EQ = 4'd7;
  localparam logic [3:0] CLS_OPERATOR  = 4'd8;
  localparam logic [3:0] CLS_DIRECTION = 4'd9;
  localparam logic [3:0] CLS_IF        = 4'd10;
  localparam logic [3:0] CLS_ASSIGN    = 4'd11;
  localparam logic [3:0] CLS_ALWAYS    = 4'd12;
  localparam logic [3:0] CLS_POSEDGE   = 4'd13;
  localparam logic [3:0] CLS_AT        = 4'd14;
  localparam logic [3:0] CLS_NAME      = 4'd15;

  // special characters
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_PIPE    = 8'h7C;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_CARET   = 8'h5E;
  localparam logic [7:0] CH_TILDE   = 8'h7E;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_AT      = 8'h40;
  localparam logic [7:0] CH_LSQUARE = 8'h5B;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  // keyword table, text right aligned, first character in the highest used byte
  localparam int NUM_KW  = 16;
  localparam int KW_REG       = 0;
  localparam int KW_WIRE      = 1;
  localparam int KW_MODULE    = 2;
  localparam int KW_ENDMODULE = 3;
  localparam int KW_BEGIN     = 4;
  localparam int KW_END       = 5;
  localparam int KW_EQ        = 6;
  localparam int KW_EQEQ      = 7;
  localparam int KW_GE        = 8;
  localparam int KW_LE        = 9;
  localparam int KW_INPUT     = 10;
  localparam int KW_OUTPUT    = 11;
  localparam int KW_IF        = 12;
  localparam int KW_ASSIGN    = 13;
  localparam int KW_ALWAYS    = 14;
  localparam int KW_POSEDGE   = 15;

  localparam logic [71:0] KW_TEXT [NUM_KW] = '{
    72'("reg"), 72'("wire"), 72'("module"), 72'("endmodule"),
    72'("begin"), 72'("end"), 72'("="), 72'("=="),
    72'(">="), 72'("<="), 72'("input"), 72'("output"),
    72'("if"), 72'("assign"), 72'("always"), 72'("posedge")
  };

  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd3, 4'd4, 4'd6, 4'd9, 4'd5, 4'd3, 4'd1, 4'd2,
    4'd2, 4'd2, 4'd5, 4'd6, 4'd2, 4'd6, 4'd6, 4'd7
  };

  typedef logic [NUM_KW-1:0] kw_vec_t;

  // controller state
  typedef enum logic [1:0] {
    S_IDLE,
    S_TOK,
    S_DLM
  } vsl_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;   // input item taken this cycle
    logic adv;      // token character taken, step to the next one
    logic sel_dlm;  // result channel shows the delimiter
  } vsl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic term_tok;  // incoming byte ends a non-empty token
    logic in_dlm;    // incoming byte is a delimiter
    logic tok_last;  // current token character is the final one
    logic dlm_pend;  // a delimiter follows the token
  } vsl_stat_t;

  // character j of keyword k, valid only for j below its length
  function automatic logic [7:0] kw_char(input int k, input logic [3:0] j);
    logic [3:0]  sh;
    logic [71:0] w;
    sh = KW_LEN[k] - 4'd1 - j;
    w  = KW_TEXT[k] >> {sh, 3'b000};
    return w[7:0];
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    case (c)
      CH_SEMI, CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN, CH_COMMA, CH_PLUS,
      CH_AMP, CH_PIPE, CH_MINUS, CH_CARET, CH_TILDE, CH_BANG, CH_COLON,
      CH_AT:   return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // class from the first character and the exact keyword hits, in priority order
  function automatic logic [3:0] class_of(input logic [7:0] f, input kw_vec_t ex);
    logic [3:0] cls;
    cls = CLS_NAME;
    if (ex[KW_REG] || ex[KW_WIRE]) cls = CLS_DECL;
    else if (ex[KW_MODULE]) cls = CLS_MODULE;
    else if (ex[KW_ENDMODULE]) cls = CLS_ENDMODULE;
    else if (f == CH_LPAREN || f == CH_RPAREN || f == CH_LBRACE || f == CH_RBRACE ||
             ex[KW_BEGIN] || ex[KW_END]) cls = CLS_BRACKET;
    else if (f == CH_COMMA) cls = CLS_COMMA;
    else if (f == CH_SEMI) cls = CLS_SEMI;
    else if ((f >= CH_ZERO && f <= CH_NINE) || f == CH_LSQUARE) cls = CLS_NUMBER;
    else if (ex[KW_EQ]) cls = CLS_ASSIGN_EQ;
    else if (f == CH_PLUS || f == CH_MINUS || f == CH_TILDE || f == CH_BANG ||
             f == CH_AMP || f == CH_PIPE || f == CH_CARET || f == CH_COLON ||
             ex[KW_EQEQ] || ex[KW_GE] || ex[KW_LE]) cls = CLS_OPERATOR;
    else if (ex[KW_INPUT] || ex[KW_OUTPUT]) cls = CLS_DIRECTION;
    else if (ex[KW_IF]) cls = CLS_IF;
    else if (ex[KW_ASSIGN]) cls = CLS_ASSIGN;
    else if (ex[KW_ALWAYS]) cls = CLS_ALWAYS;
    else if (ex[KW_POSEDGE]) cls = CLS_POSEDGE;
    else if (f == CH_AT) cls = CLS_AT;
    return cls;
  endfunction

endpackage

@@ rtl/vsl_ifs.sv @@
// valid/ready channel interfaces for the byte input and the token output
// no dependencies
interface vsl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface vsl_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  token_char;
  logic [3:0]  token_class;
  logic [15:0] line_number;
  logic        token_last;
  logic        token_truncated;

  modport source (output valid, output token_char, output token_class,
                  output line_number, output token_last, output token_truncated,
                  input ready);
  modport sink   (input valid, input token_char, input token_class,
                  input line_number, input token_last, input token_truncated,
                  output ready);
endinterface

@@ rtl/vsl_ctrl.sv @@
// lexer controller: sequences byte intake and token character output
// depends on vsl_pkg
module vsl_ctrl import vsl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  vsl_stat_t stat,
  output vsl_cmd_t  cmd
);

  vsl_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd.accept  = 1'b0;
    cmd.adv     = 1'b0;
    cmd.sel_dlm = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          if (stat.term_tok) begin
            state_nxt = S_TOK;
          end else if (stat.in_dlm) begin
            state_nxt = S_DLM;
          end
        end
      end
      S_TOK: begin
        out_valid = 1'b1;
        cmd.adv   = out_ready;
        if (out_ready && stat.tok_last) begin
          state_nxt = stat.dlm_pend ? S_DLM : S_IDLE;
        end
      end
      S_DLM: begin
        out_valid   = 1'b1;
        cmd.sel_dlm = 1'b1;
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/vsl_dpath.sv @@
// lexer datapath: token buffer memory, keyword matchers, line counter, output registers
// depends on vsl_pkg and the assertion macro header
`include "verilog_subset_lexer_unit_macros.svh"

module vsl_dpath import vsl_pkg::*; #(
  parameter int TOKEN_CHARS = 31,
  parameter int LINE_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_char,
  input  vsl_cmd_t    cmd,
  output vsl_stat_t   stat,
  output logic [7:0]  token_char,
  output logic [3:0]  token_class,
  output logic [15:0] line_number,
  output logic        token_last,
  output logic        token_truncated
);

  localparam int AW = $clog2(TOKEN_CHARS);
  localparam int CW = $clog2(TOKEN_CHARS + 1);
  localparam logic [CW-1:0] FULL = CW'(TOKEN_CHARS);
  localparam logic [LINE_BITS-1:0] LINE_MAX = '1;
  localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

  // token buffer
  logic [7:0] mem [TOKEN_CHARS];

  // pending token state
  logic [CW-1:0]        len_r;
  logic                 ovf_r;
  logic [7:0]           first_r;
  kw_vec_t              match_r;
  logic [LINE_BITS-1:0] line_r;

  // emitted token state
  logic [CW-1:0] tok_len_r;
  logic [3:0]    tok_cls_r;
  logic          tok_trunc_r;
  logic [15:0]   tok_line_r;
  logic [AW-1:0] rd_idx_r;
  logic [7:0]    rd_q_r;
  logic          dlm_pend_r;
  logic [7:0]    dlm_char_r;
  logic [3:0]    dlm_cls_r;

  logic                   in_is_dlm;
  logic                   in_is_term;
  logic                   wr_en;
  logic [AW-1:0]          rd_addr;
  kw_vec_t                match_upd;
  kw_vec_t                exact;
  logic [LINE_BITS+15:0]  line_ext;

  // byte decode
  assign in_is_dlm  = is_delim(in_char);
  assign in_is_term = in_is_dlm || in_char == CH_SPACE || in_char == CH_NL ||
                      in_char == CH_NUL;
  assign wr_en      = cmd.accept && !in_is_term && len_r < FULL;
  assign rd_addr    = cmd.accept ? '0 : rd_idx_r + AW'(1);
  assign line_ext   = {16'b0, line_r};

  // keyword matchers, one per keyword, stepped by each kept character
  always_comb begin
    for (int k = 0; k < NUM_KW; k++) begin
      match_upd[k] = (len_r == '0 || match_r[k]) && len_r < CW'(KW_LEN[k]) &&
                     in_char == kw_char(k, len_r[3:0]);
      exact[k]     = match_r[k] && len_r == CW'(KW_LEN[k]);
    end
  end

  // buffer write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[len_r[AW-1:0]] <= in_char;
    end
    if (cmd.accept || cmd.adv) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // pending token and line counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r      <= '0;
      ovf_r      <= 1'b0;
      match_r    <= '0;
      line_r     <= LINE_ONE;
      dlm_pend_r <= 1'b0;
    end else if (cmd.accept) begin
      if (in_is_term) begin
        len_r      <= '0;
        ovf_r      <= 1'b0;
        match_r    <= '0;
        dlm_pend_r <= in_is_dlm;
        if (in_char == CH_NL && line_r != LINE_MAX) begin
          line_r <= line_r + LINE_ONE;
        end else if (in_char == CH_NUL) begin
          line_r <= LINE_ONE;
        end
      end else if (len_r < FULL) begin
        len_r   <= len_r + CW'(1);
        match_r <= match_upd;
      end else begin
        ovf_r <= 1'b1;
      end
    end
  end

  // token snapshot at the terminating byte
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      tok_line_r <= line_ext[15:0];
      dlm_char_r <= in_char;
      dlm_cls_r  <= class_of(in_char, '0);
      if (!in_is_term && len_r == '0) begin
        first_r <= in_char;
      end
      if (in_is_term) begin
        tok_len_r   <= len_r;
        tok_cls_r   <= class_of(first_r, exact);
        tok_trunc_r <= ovf_r;
      end
    end
  end

  // read index
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_idx_r <= '0;
    end else if (cmd.adv) begin
      rd_idx_r <= rd_idx_r + AW'(1);
    end
  end

  // status
  assign stat.term_tok = in_is_term && len_r != '0;
  assign stat.in_dlm   = in_is_dlm;
  assign stat.tok_last = CW'(rd_idx_r) + CW'(1) == tok_len_r;
  assign stat.dlm_pend = dlm_pend_r;

  // result payload
  assign token_char      = cmd.sel_dlm ? dlm_char_r : rd_q_r;
  assign token_class     = cmd.sel_dlm ? dlm_cls_r : tok_cls_r;
  assign line_number     = tok_line_r;
  assign token_last      = cmd.sel_dlm || stat.tok_last;
  assign token_truncated = !cmd.sel_dlm && tok_trunc_r;

  // checks
  `VSL_ASSERT_IMP(a_ovf_needs_full, ovf_r, len_r == FULL)
  `VSL_ASSERT_IMP(a_line_nonzero, 1'b1, line_r != '0)
  `VSL_ASSERT_NXT(a_flush_clears, cmd.accept && in_is_term, len_r == '0 && !ovf_r)
  `VSL_ASSERT_NXT(a_rd_step, cmd.adv && !cmd.accept, rd_idx_r == $past(rd_idx_r) + AW'(1))

endmodule

@@ rtl/verilog_subset_lexer_unit.sv @@
// lexer top level: an ordinary byte is taken whenever the controller is idle; a terminating
// byte holds off input while the token characters are sent, at one character a cycle while
// the receiver is ready, from the token buffer memory (registered read), then any trailing delimiter token.
// first character appears in the cycle after the terminating byte is taken.
// synchronous active-low reset: buffer empty, overflow flag clear, line counter at 1,
// controller idle; the buffer memory itself is not cleared.
module verilog_subset_lexer_unit import vsl_pkg::*; #(
  parameter int TOKEN_CHARS = 31,
  parameter int LINE_BITS   = 16
) (
  input logic       clk,
  input logic       rst_n,
  vsl_in_if.sink    in_if,
  vsl_out_if.source out_if
);

  vsl_cmd_t  cmd;
  vsl_stat_t stat;

  // controller
  vsl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath
  vsl_dpath #(
    .TOKEN_CHARS (TOKEN_CHARS),
    .LINE_BITS   (LINE_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_char         (in_if.char_code),
    .cmd             (cmd),
    .stat            (stat),
    .token_char      (out_if.token_char),
    .token_class     (out_if.token_class),
    .line_number     (out_if.line_number),
    .token_last      (out_if.token_last),
    .token_truncated (out_if.token_truncated)
  );

endmodule

@@ test/tb_top.sv @@
// self-checking bench for verilog_subset_lexer_unit: a byte stream goes in, and a token
// predictor builds the expected characters, classes, lines and flags
// depends on vsl_pkg (rtl/vsl_pkg.sv) and the channel interfaces (rtl/vsl_ifs.sv)
module tb_top;
  import vsl_pkg::*;

  localparam int TOKEN_CHARS = 31;
  localparam int LINE_MAX    = 65535;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_WAIT  = 40;

  // one character of an emitted token
  typedef struct packed {
    logic [7:0]  ch;
    logic [3:0]  cls;
    logic [15:0] line;
    logic        last;
    logic        trunc;
  } token_beat_t;

  logic clk;
  logic rst_n;

  vsl_in_if  in_if ();
  vsl_out_if out_if ();

  verilog_subset_lexer_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  // token predictor state
  logic [7:0]  pend_text [TOKEN_CHARS];
  int          pend_len;
  bit          pend_ovf;
  int          line_cnt;
  token_beat_t token_q [$];

  int errors;
  int chars_sent;
  int stall_cycles;
  int hold_cycles;
  bit src_idle_on;
  bit sink_idle_on;

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic bit is_delimiter(input logic [7:0] c);
    case (c)
      ";", "{", "}", "(", ")", ",", "+", "&", "|", "-", "^", "~", "!", ":", "@":
        return 1'b1;
      default:
        return 1'b0;
    endcase
  endfunction

  function automatic bit spells(input logic [71:0] acc, input int n,
                                input logic [71:0] word, input int wl);
    return (n == wl) && (acc == word);
  endfunction

  // keywords need the whole token; single-character classes look at the first byte only
  function automatic logic [3:0] class_of_token(input logic [7:0] f, input logic [71:0] acc,
                                                input int n);
    if (spells(acc, n, "reg", 3) || spells(acc, n, "wire", 4)) return CLS_DECL;
    if (spells(acc, n, "module", 6)) return CLS_MODULE;
    if (spells(acc, n, "endmodule", 9)) return CLS_ENDMODULE;
    if (f == "(" || f == ")" || f == "{" || f == "}" ||
        spells(acc, n, "begin", 5) || spells(acc, n, "end", 3)) return CLS_BRACKET;
    if (f == ",") return CLS_COMMA;
    if (f == ";") return CLS_SEMI;
    if ((f >= "0" && f <= "9") || f == "[") return CLS_NUMBER;
    if (spells(acc, n, "=", 1)) return CLS_ASSIGN_EQ;
    if (f == "+" || f == "-" || f == "~" || f == "!" || f == "&" || f == "|" ||
        f == "^" || f == ":" || spells(acc, n, "==", 2) || spells(acc, n, ">=", 2) ||
        spells(acc, n, "<=", 2)) return CLS_OPERATOR;
    if (spells(acc, n, "input", 5) || spells(acc, n, "output", 6)) return CLS_DIRECTION;
    if (spells(acc, n, "if", 2)) return CLS_IF;
    if (spells(acc, n, "assign", 6)) return CLS_ASSIGN;
    if (spells(acc, n, "always", 6)) return CLS_ALWAYS;
    if (spells(acc, n, "posedge", 7)) return CLS_POSEDGE;
    if (f == "@") return CLS_AT;
    return CLS_NAME;
  endfunction

  // pending token goes out one character per beat, then the buffer empties
  function automatic void flush_pending();
    logic [71:0] acc;
    logic [3:0]  cls;
    token_beat_t b;
    acc = '0;
    for (int i = 0; i < pend_len && i < 9; i++) acc = {acc[63:0], pend_text[i]};
    if (pend_len > 0) begin
      cls = class_of_token(pend_text[0], acc, pend_len);
      for (int i = 0; i < pend_len; i++) begin
        b.ch    = pend_text[i];
        b.cls   = cls;
        b.line  = line_cnt[15:0];
        b.last  = (i == pend_len - 1);
        b.trunc = pend_ovf;
        token_q.push_back(b);
      end
    end
    pend_len = 0;
    pend_ovf = 1'b0;
  endfunction

  function automatic void lex_byte(input logic [7:0] c);
    token_beat_t b;
    if (is_delimiter(c)) begin
      flush_pending();
      b.ch    = c;
      b.cls   = class_of_token(c, {64'd0, c}, 1);
      b.line  = line_cnt[15:0];
      b.last  = 1'b1;
      b.trunc = 1'b0;
      token_q.push_back(b);
    end else if (c == " ") begin
      flush_pending();
    end else if (c == "\n") begin
      flush_pending();
      if (line_cnt < LINE_MAX) line_cnt++;
    end else if (c == 8'h00) begin
      flush_pending();
      line_cnt = 1;
    end else if (pend_len < TOKEN_CHARS) begin
      pend_text[pend_len] = c;
      pend_len++;
    end else begin
      pend_ovf = 1'b1;
    end
  endfunction

  // send one byte: optional idle cycles, then hold valid until the handshake
  task automatic send_char(input logic [7:0] c);
    if (src_idle_on)
      while ($urandom_range(0, 99) < 18) begin
        in_if.valid <= 1'b0;
        @(negedge clk);
      end
    in_if.valid     <= 1'b1;
    in_if.char_code <= c;
    do @(posedge clk); while (!in_if.ready);
    lex_byte(c);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // drop valid and wait until every expected character has come out
  task automatic drain();
    in_if.valid <= 1'b0;
    @(negedge clk);
    while (token_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic string keyword_text(input int k);
    string s;
    case (k)
      0:       s = "reg";
      1:       s = "wire";
      2:       s = "module";
      3:       s = "endmodule";
      4:       s = "begin";
      5:       s = "end";
      6:       s = "=";
      7:       s = "==";
      8:       s = ">=";
      9:       s = "<=";
      10:      s = "input";
      11:      s = "output";
      12:      s = "if";
      13:      s = "assign";
      14:      s = "always";
      default: s = "posedge";
    endcase
    return s;
  endfunction

  function automatic logic [7:0] delim_byte(input int k);
    logic [7:0] c;
    case (k)
      0:       c = ";";
      1:       c = "{";
      2:       c = "}";
      3:       c = "(";
      4:       c = ")";
      5:       c = ",";
      6:       c = "+";
      7:       c = "&";
      8:       c = "|";
      9:       c = "-";
      10:      c = "^";
      11:      c = "~";
      12:      c = "!";
      13:      c = ":";
      default: c = "@";
    endcase
    return c;
  endfunction

  // any byte that just extends the pending token
  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (is_delimiter(c) || c == " " || c == "\n");
    return c;
  endfunction

  // every delimiter, alone and right after a token, and end of text with nothing pending
  task automatic test_delimiters();
    send_char(8'h00);
    for (int k = 0; k < 15; k++) send_char(delim_byte(k));
    send_text("a;b@");
    send_char(8'h00);
    drain();
  endtask

  // all keywords, near misses and the number forms
  task automatic test_keywords();
    for (int k = 0; k < 16; k++) begin
      send_text(keyword_text(k));
      send_char((k % 2) ? "\n" : " ");
    end
    send_text("regs en ends =< === [7 9x _if\n");
    drain();
  endtask

  // exactly full buffer, then a token that overflows, then end of text mid token
  task automatic test_overflow();
    for (int i = 0; i < TOKEN_CHARS; i++) send_char(8'h61 + 8'(i % 26));
    send_char(" ");
    send_char(8'hFF);
    send_char(8'h01);
    for (int i = 0; i < 38; i++) send_char(8'h80 + 8'(i));
    send_char(",");
    send_text("module");
    for (int i = 0; i < 30; i++) send_char("x");
    send_char("\n");
    send_text("abc");
    send_char(8'h00);
    send_text("z\n");
    drain();
  endtask

  // newlines advance the line counter, then end of text sets it back to one
  task automatic test_line_reset();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    send_char(8'h00);
    for (int i = 0; i < 6; i++) send_char("\n");
    send_text("top;\n");
    send_char(8'h00);
    send_text("w\n");
    drain();
  endtask

  // receiver stops for a long stretch while the sender keeps offering bytes
  task automatic test_backpressure();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    hold_cycles  = 400;
    repeat (2) send_text("always @(posedge clk) begin q <= d; end\n");
    drain();
  endtask

  // mostly well-formed text with random content, some noise
  task automatic test_random_text(input int n_items, input bit idle);
    int          start;
    int          r;
    int          len;
    logic [7:0]  c;
    src_idle_on  = idle;
    sink_idle_on = idle;
    start = chars_sent;
    while (chars_sent - start < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        send_text(keyword_text($urandom_range(0, 15)));
      end else if (r < 60) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++) send_char(plain_byte());
      end else if (r < 70) begin
        send_char(($urandom_range(0, 3) == 0) ? "[" : 8'("0" + $urandom_range(0, 9)));
        len = $urandom_range(0, 4);
        for (int i = 0; i < len; i++) send_char(8'("0" + $urandom_range(0, 9)));
      end else if (r < 85) begin
        send_char(delim_byte($urandom_range(0, 14)));
      end else if (r < 98) begin
        send_char(8'($urandom_range(0, 255)));
      end else begin
        send_char(8'h00);
      end
      // separator, or none so that pieces run together
      r = $urandom_range(0, 9);
      if (r < 4) c = " ";
      else if (r < 6) c = "\n";
      else if (r < 8) c = delim_byte($urandom_range(0, 14));
      else c = 8'h00;
      if (c != 8'h00) send_char(c);
    end
    drain();
  endtask

  // receiver: long hold when asked, otherwise random stalls if sink idling is on, else always ready
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_if.ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_if.ready <= !sink_idle_on || ($urandom_range(0, 99) >= 18);
      end
    end
  end

  function automatic void check_field(input string fld, input logic [15:0] exp_v,
                                      input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      if (errors <= 40)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fld, exp_v, act_v);
    end
  endfunction

  // compare each token character with the oldest expected one
  always @(posedge clk) begin
    token_beat_t b;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (token_q.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: unexpected character, expected none, actual %0h",
                   $time, out_if.token_char);
      end else begin
        b = token_q.pop_front();
        check_field("token_char", 16'(b.ch), 16'(out_if.token_char));
        check_field("token_class", 16'(b.cls), 16'(out_if.token_class));
        check_field("line_number", b.line, out_if.line_number);
        check_field("token_last", 16'(b.last), 16'(out_if.token_last));
        check_field("token_truncated", 16'(b.trunc), 16'(out_if.token_truncated));
      end
    end
  end

  // watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.char_code = 8'h00;
    errors          = 0;
    chars_sent      = 0;
    stall_cycles    = 0;
    hold_cycles     = 0;
    src_idle_on     = 1'b1;
    sink_idle_on    = 1'b1;
    pend_len        = 0;
    pend_ovf        = 1'b0;
    line_cnt        = 1;
    for (int i = 0; i < TOKEN_CHARS; i++) pend_text[i] = 8'h00;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_delimiters();
    test_keywords();
    test_overflow();
    test_backpressure();
    test_random_text(40, 1'b0);
    test_random_text(120, 1'b1);
    test_line_reset();

    while (token_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
